// ----- sv/tiac_pkg.sv -----
package tiac_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_DONT = 8'd254;

  // Input commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_REFUSE = 2'd3;

  // Job queue between parser and result stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] net_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    JOB_REPLY  = 2'd0,
    JOB_DATA   = 2'd1,
    JOB_EMPTY  = 2'd2,
    JOB_REFUSE = 2'd3
  } job_op_e;

  typedef struct packed {
    job_op_e    op;
    logic [7:0] arg;   // option byte or data byte
    logic       dont;  // reply with DONT, else WONT
  } job_t;

  typedef enum logic [4:0] {
    PS_NORMAL = 5'b00001,
    PS_IAC    = 5'b00010,
    PS_DONT   = 5'b00100,
    PS_WONT   = 5'b01000,
    PS_SKIP   = 5'b10000
  } parse_state_t;

endpackage

// ----- sv/telnet_iac_filter_with_rx_fifo.sv -----
// Telnet receive filter. Each input word carries a command: a network byte,
// a read of one stored character, or a close. Plain data bytes and escaped
// IAC IAC pairs are stored in a ring FIFO of FIFO_DEPTH entries holding up
// to FIFO_DEPTH-1 bytes; IAC WILL x is answered with IAC DONT x and IAC DO x
// with IAC WONT x as three reply words, IAC WONT/DONT x drop x, and other
// IAC commands are dropped. A read returns one data word or an empty word.
// A byte that would overflow the FIFO is refused with one word and must be
// resent; the parser holds its state for it. Close resets the parser and
// empties the FIFO without producing a word. Throughput is one input word
// per cycle while in_ready is high: the parser and FIFO update together,
// and results go through a four-entry job queue to an output register
// that emits one word per cycle while out_ready is high, so an option
// reply takes three output words. in_ready drops only when the job
// queue, counting the job staged behind the FIFO read port, is full. A
// read result passes the staging register, job queue and output register.
module telnet_iac_filter_with_rx_fifo import tiac_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic           q_push;
  job_t           q_job;
  logic           q_pop;
  logic           head_valid;
  job_t           head_job;
  logic [QLW-1:0] q_level;

  // Parse, update FIFO, stage jobs that produce results
  tiac_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Decouple parser from output stalls
  tiac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (q_level)
  );

  // Expand each job into its result words
  tiac_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- sv/tiac_front.sv -----
module tiac_front import tiac_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  item_t          in_data,
  input  logic [QLW-1:0] q_level,
  output logic           q_push,
  output job_t           q_job
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    mem [FIFO_DEPTH];
  logic [7:0]    mem_q;

  parse_state_t  state, state_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic          s_valid;
  job_t          s_job;

  logic          accept;
  logic          full;
  logic          push_en;
  logic          pop_en;
  logic          gen;
  job_t          gen_job;

  // Count the staged job against queue space so a push always fits
  assign in_ready = ({1'b0, q_level} + (QLW + 1)'(s_valid)) < (QLW + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign full     = (ptr_inc(wr_ptr) == rd_ptr);

  always_comb begin
    state_next  = state;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    push_en     = 1'b0;
    pop_en      = 1'b0;
    gen         = 1'b0;
    gen_job     = '{op: JOB_REFUSE, arg: 8'd0, dont: 1'b0};
    if (accept) begin
      case (in_data.cmd)
        CMD_READ: begin
          gen = 1'b1;
          if (rd_ptr != wr_ptr) begin
            pop_en      = 1'b1;
            rd_ptr_next = ptr_inc(rd_ptr);
            gen_job.op  = JOB_DATA;
          end else begin
            gen_job.op  = JOB_EMPTY;
          end
        end
        CMD_CLOSE: begin
          state_next  = PS_NORMAL;
          wr_ptr_next = '0;
          rd_ptr_next = '0;
        end
        CMD_BYTE: begin
          case (state)
            PS_NORMAL: begin
              if (full) begin
                gen = 1'b1;
              end else if (in_data.net_byte == TN_IAC) begin
                state_next = PS_IAC;
              end else begin
                push_en = 1'b1;
              end
            end
            PS_IAC: begin
              if (in_data.net_byte == TN_WILL) begin
                state_next = PS_DONT;
              end else if (in_data.net_byte == TN_DO) begin
                state_next = PS_WONT;
              end else if (in_data.net_byte == TN_WONT || in_data.net_byte == TN_DONT) begin
                state_next = PS_SKIP;
              end else if (in_data.net_byte == TN_IAC) begin
                // hold in IAC when full so the resent byte completes the pair
                if (full) begin
                  gen = 1'b1;
                end else begin
                  push_en    = 1'b1;
                  state_next = PS_NORMAL;
                end
              end else begin
                state_next = PS_NORMAL;
              end
            end
            PS_DONT, PS_WONT: begin
              gen          = 1'b1;
              gen_job.op   = JOB_REPLY;
              gen_job.arg  = in_data.net_byte;
              gen_job.dont = (state == PS_DONT);
              state_next   = PS_NORMAL;
            end
            default: begin
              state_next = PS_NORMAL;
            end
          endcase
          if (push_en) begin
            wr_ptr_next = ptr_inc(wr_ptr);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= PS_NORMAL;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      s_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_ptr  <= wr_ptr_next;
      rd_ptr  <= rd_ptr_next;
      s_valid <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      s_job <= gen_job;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr] <= in_data.net_byte;
    end
    if (pop_en) begin
      mem_q <= mem[rd_ptr];
    end
  end

  assign q_push = s_valid;

  always_comb begin
    q_job = s_job;
    if (s_job.op == JOB_DATA) begin
      q_job.arg = mem_q;
    end
  end

endmodule

// ----- sv/tiac_queue.sv -----
module tiac_queue import tiac_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  job_t           push_job,
  input  logic           pop,
  output logic           head_valid,
  output job_t           head_job,
  output logic [QLW-1:0] level
);

  job_t           slots [QDEPTH];
  logic [QAW-1:0] wr_idx;
  logic [QAW-1:0] rd_idx;

  assign head_valid = (level != '0);
  assign head_job   = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + QAW'(1);
      end
      if (pop) begin
        rd_idx <= rd_idx + QAW'(1);
      end
      level <= level + QLW'(push) - QLW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_job;
    end
  end

endmodule

// ----- sv/tiac_back.sv -----
module tiac_back import tiac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  job_t    head_job,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [1:0] idx;
  logic       load;
  logic       final_word;
  result_t    word;

  always_comb begin
    word       = '{kind: KIND_REFUSE, out_byte: 8'd0, last: 1'b1};
    final_word = 1'b1;
    case (head_job.op)
      JOB_REPLY: begin
        word.kind = KIND_REPLY;
        case (idx)
          2'd0: begin
            word.out_byte = TN_IAC;
            word.last     = 1'b0;
            final_word    = 1'b0;
          end
          2'd1: begin
            word.out_byte = head_job.dont ? TN_DONT : TN_WONT;
            word.last     = 1'b0;
            final_word    = 1'b0;
          end
          default: begin
            word.out_byte = head_job.arg;
          end
        endcase
      end
      JOB_DATA: begin
        word.kind     = KIND_DATA;
        word.out_byte = head_job.arg;
      end
      JOB_EMPTY: begin
        word.kind = KIND_EMPTY;
      end
      default: begin
      end
    endcase
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_word ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

endmodule

// ----- sv/tiac_checker.sv -----
module tiac_checker import tiac_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Come out of reset empty and ready for input
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle right after reset");

  // IAC opening a reply is followed at once by DONT or WONT
  a_reply_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.kind == KIND_REPLY && !out_data.last &&
    out_data.out_byte == TN_IAC
    |=> out_valid && out_data.kind == KIND_REPLY && !out_data.last &&
        (out_data.out_byte == TN_DONT || out_data.out_byte == TN_WONT))
    else $error("reply sequence broken");

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_EMPTY || out_data.kind == KIND_REFUSE)
    |-> out_data.out_byte == 8'd0 && out_data.last)
    else $error("status word not zero or not last");

endmodule

bind telnet_iac_filter_with_rx_fifo tiac_checker u_tiac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/telnet_rx_checker.sv -----
module telnet_rx_checker import tiac_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_ready,
  input  item_t   in_data,
  input  logic    out_valid,
  input  logic    out_ready,
  input  result_t out_data,
  output int      fail_count,
  output int      words_due,
  output int      words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the filter: parser phase, receive store and its pointers.
  parse_state_t parse_phase;
  logic [7:0]   rx_store [FIFO_DEPTH];
  int           wr_ptr;
  int           rd_ptr;
  result_t      due_words [$];
  int           mismatches = 0;
  int           checked = 0;

  function automatic int bump_ptr(input int p);
    return (p + 1 == FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic bit store_full();
    return bump_ptr(wr_ptr) == rd_ptr;
  endfunction

  function automatic result_t reply_word(input logic [1:0] k, input logic [7:0] b,
                                         input logic l);
    result_t r;
    r.kind     = k;
    r.out_byte = b;
    r.last     = l;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 20)
      $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advance the shadow by one accepted word and queue the words it causes.
  task automatic parse_rx_word(input item_t w);
    logic [7:0] b;
    b = w.net_byte;
    case (w.cmd)
      CMD_READ: begin
        if (rd_ptr != wr_ptr) begin
          due_words.push_back(reply_word(KIND_DATA, rx_store[rd_ptr], 1'b1));
          rd_ptr = bump_ptr(rd_ptr);
        end else begin
          due_words.push_back(reply_word(KIND_EMPTY, 8'h00, 1'b1));
        end
      end
      CMD_CLOSE: begin
        parse_phase = PS_NORMAL;
        wr_ptr      = 0;
        rd_ptr      = 0;
      end
      CMD_BYTE: begin
        case (parse_phase)
          PS_NORMAL: begin
            if (store_full()) begin
              due_words.push_back(reply_word(KIND_REFUSE, 8'h00, 1'b1));
            end else if (b == TN_IAC) begin
              parse_phase = PS_IAC;
            end else begin
              rx_store[wr_ptr] = b;
              wr_ptr = bump_ptr(wr_ptr);
            end
          end
          PS_IAC: begin
            if (b == TN_WILL) begin
              parse_phase = PS_DONT;
            end else if (b == TN_DO) begin
              parse_phase = PS_WONT;
            end else if (b == TN_WONT || b == TN_DONT) begin
              parse_phase = PS_SKIP;
            end else if (b == TN_IAC) begin
              if (store_full()) begin
                due_words.push_back(reply_word(KIND_REFUSE, 8'h00, 1'b1));
              end else begin
                rx_store[wr_ptr] = b;
                wr_ptr = bump_ptr(wr_ptr);
                parse_phase = PS_NORMAL;
              end
            end else begin
              parse_phase = PS_NORMAL;
            end
          end
          PS_DONT, PS_WONT: begin
            due_words.push_back(reply_word(KIND_REPLY, TN_IAC, 1'b0));
            due_words.push_back(reply_word(KIND_REPLY,
                                           (parse_phase == PS_DONT) ? TN_DONT : TN_WONT,
                                           1'b0));
            due_words.push_back(reply_word(KIND_REPLY, b, 1'b1));
            parse_phase = PS_NORMAL;
          end
          default: parse_phase = PS_NORMAL;
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      parse_phase = PS_NORMAL;
      wr_ptr      = 0;
      rd_ptr      = 0;
      due_words.delete();
    end else begin
      if (in_valid && in_ready)
        parse_rx_word(in_data);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d byte %02h last %0d",
                                    out_data.kind, out_data.out_byte, out_data.last));
        end else begin
          want = due_words.pop_front();
          checked++;
          if (out_data.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("byte %02h, expected %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", out_data.last, want.last));
        end
      end
    end
    fail_count    <= mismatches;
    words_due     <= due_words.size();
    words_checked <= checked;
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import tiac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIFO_DEPTH       = 16;
  localparam int ITEM_TARGET      = 170;  // stop the random part near this many words
  localparam int CALM_AFTER       = 140;  // no idling on either side past this point
  localparam int SINK_HOLD_CYCLES = 80;   // long output stall used to back up the input
  localparam int STALL_LIMIT      = 2000; // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES     = 20;   // quiet tail to catch stray result words

  // Spare command code: the filter must ignore it.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  item_t   in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;

  int fail_count;
  int words_due;
  int words_checked;
  int sent_words = 0;   // accepted words that the filter acts on
  int fills = 0;
  int holds = 0;
  int stuck = 0;
  bit calm = 1'b0;      // set for the last part of the run: no idling
  bit sink_hold_req = 1'b0;

  always #10ns clk = ~clk;

  telnet_iac_filter_with_rx_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Scoreboard sits beside the filter, watching both channels.
  telnet_rx_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  function automatic item_t byte_word(input logic [7:0] b);
    item_t w;
    w.cmd      = CMD_BYTE;
    w.net_byte = b;
    return w;
  endfunction

  // The byte field is unused on a read or close, so fill it with noise.
  function automatic item_t ctl_word(input logic [1:0] c);
    item_t w;
    w.cmd      = c;
    w.net_byte = 8'($urandom);
    return w;
  endfunction

  // Offer one word and hold it until accepted. Now and then idle first;
  // valid stays high into the next word otherwise.
  task automatic send_word(input item_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.cmd != CMD_SPARE)
      sent_words++;
  endtask

  task automatic send_iac(input logic [7:0] second);
    send_word(byte_word(TN_IAC));
    send_word(byte_word(second));
  endtask

  // Pause the sender until every predicted result word has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // Fill the receive store to the brim, hit the refusal cases, top it off
  // with an escaped IAC, then drain it past empty.
  task automatic fill_store();
    send_word(ctl_word(CMD_CLOSE));
    repeat (FIFO_DEPTH - 1) send_word(byte_word(8'($urandom_range(0, 254))));
    send_word(byte_word(8'($urandom_range(0, 254))));  // refused, full
    send_word(byte_word(TN_IAC));                      // refused too, parser stays put
    send_word(ctl_word(CMD_READ));                     // free one slot
    send_iac(TN_IAC);                                  // escaped 255 takes the last slot
    send_word(byte_word(8'($urandom)));                // refused again
    repeat (FIFO_DEPTH) send_word(ctl_word(CMD_READ));
    fills++;
  endtask

  // Stall the output for a long stretch while reads and option requests
  // keep coming, so the job queue fills and input ready drops.
  task automatic back_up_output();
    repeat (4) send_word(byte_word(8'($urandom_range(0, 254))));
    sink_hold_req = 1'b1;
    repeat (6) begin
      send_word(ctl_word(CMD_READ));
      send_iac(TN_DO);
      send_word(byte_word(8'($urandom)));
    end
    holds++;
  endtask

  // One random sequence: mostly well-formed telnet traffic with random
  // content, some reads and closes, and a little raw noise.
  task automatic random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 6) == 0)
          send_iac(TN_IAC);
        else
          send_word(byte_word(8'($urandom_range(0, 254))));
      end
    end else if (pick < 45) begin
      case ($urandom_range(0, 3))
        0: send_iac(TN_WILL);
        1: send_iac(TN_DO);
        2: send_iac(TN_WONT);
        default: send_iac(TN_DONT);
      endcase
      send_word(byte_word(8'($urandom)));
    end else if (pick < 52) begin
      send_iac(8'($urandom_range(0, 250)));   // command the filter just drops
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 4)) send_word(ctl_word(CMD_READ));
    end else if (pick < 84) begin
      send_word(ctl_word(CMD_CLOSE));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        item_t w;
        w.cmd      = 2'($urandom_range(0, 3));
        w.net_byte = 8'($urandom);
        send_word(w);
      end
    end
  endtask

  // Output side: ready with random stall bursts, plus the long hold when
  // asked for. Count the hold in this process so the sender keeps going.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  initial begin
    while (rst) @(posedge clk);
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty read, data extremes, escaped IAC, every option verb,
    // a dropped command, the spare command, and a close in mid-escape.
    send_word(ctl_word(CMD_READ));
    send_word(byte_word(8'h00));
    send_word(byte_word(TN_DONT));         // command values are plain data here
    send_iac(TN_IAC);
    send_word(byte_word(TN_WILL));
    repeat (5) send_word(ctl_word(CMD_READ));
    send_iac(TN_WILL);
    send_word(byte_word(8'h01));
    send_iac(TN_DO);
    send_word(byte_word(TN_IAC));          // option 255 is echoed, not escaped
    send_iac(TN_WONT);
    send_word(byte_word(8'h18));
    send_iac(TN_DONT);
    send_word(byte_word(TN_IAC));          // skipped option, not a new IAC
    send_iac(8'hF1);
    send_word(ctl_word(CMD_SPARE));
    send_word(byte_word(TN_IAC));
    send_word(ctl_word(CMD_CLOSE));        // drop the pending escape
    send_word(byte_word(8'h41));
    send_word(ctl_word(CMD_READ));
    settle();

    back_up_output();
    settle();
    fill_store();
    settle();

    while (sent_words < ITEM_TARGET / 2) random_burst();
    settle();
    fill_store();

    while (sent_words < ITEM_TARGET) begin
      if (sent_words >= CALM_AFTER)
        calm = 1'b1;
      random_burst();
    end

    // Drain: wait out every predicted word, then a quiet tail.
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d input words accepted, %0d result words checked",
             sent_words, words_checked);
    $display("run: %0d full-store fills, %0d long output stalls", fills, holds);
    if (fail_count == 0 && words_due == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- telnet_iac_filter_with_rx_fifo.f -----
sv/tiac_pkg.sv
sv/tiac_front.sv
sv/tiac_queue.sv
sv/tiac_back.sv
sv/telnet_iac_filter_with_rx_fifo.sv
sv/tiac_checker.sv
tb/sv/telnet_rx_checker.sv
tb/sv/tb.sv
